[rtl/core/owbm_pkg.sv]
// shared types and constants for the one-wire bus master
`default_nettype none

package owbm_pkg;

	// sequence the back end is running
	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// item kinds on the input stream
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// phase lengths in microseconds
	localparam logic [8:0] T_RST_LOW     = 9'd480;
	localparam logic [8:0] T_RST_SAMPLE  = 9'd70;
	localparam logic [8:0] T_RST_TAIL    = 9'd410;
	localparam logic [8:0] T_W1_LOW      = 9'd6;
	localparam logic [8:0] T_W1_REL      = 9'd64;
	localparam logic [8:0] T_W0_LOW      = 9'd60;
	localparam logic [8:0] T_W0_REL      = 9'd10;
	localparam logic [8:0] T_RD_LOW      = 9'd6;
	localparam logic [8:0] T_RD_SAMPLE   = 9'd1;
	localparam logic [8:0] T_RD_TAIL     = 9'd55;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	localparam int QDEPTH = 2;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_cmd;
		op_t        op;
		logic [7:0] data;
		logic       level;
	} item_t;

endpackage

`default_nettype wire

[rtl/core/owbm_front.sv]
// front end: accepts stream transfers, classifies them, queues them for the sequencer
`default_nettype none

module owbm_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [1:0]        in_kind,
	input  wire  [7:0]        in_data,
	input  wire               in_level,
	output logic              q_valid,
	output owbm_pkg::item_t   q_item,
	input  wire               q_pop
);
	import owbm_pkg::*;

	item_t      ent_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// classify the incoming kind
	always_comb begin
		cls.data  = in_data;
		cls.level = in_level;
		unique case (in_kind)
			KIND_TICK: begin
				cls.is_cmd = 1'b0;
				cls.op     = OP_IDLE;
			end
			KIND_RESET: begin
				cls.is_cmd = 1'b1;
				cls.op     = OP_RESET;
			end
			KIND_WRITE: begin
				cls.is_cmd = 1'b1;
				cls.op     = OP_WRITE;
			end
			default: begin
				cls.is_cmd = 1'b1;
				cls.op     = OP_READ;
			end
		endcase
	end

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH))
		else $error("queue count over depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[rtl/core/owbm_back.sv]
// back end: bus sequencer for reset, write byte and read byte, with registered result
`default_nettype none

module owbm_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	input  owbm_pkg::item_t   q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [15:0]       out_data
);
	import owbm_pkg::*;

	op_t        op_q,    op_n;
	logic [1:0] phase_q, phase_n;
	logic [8:0] cnt_q,   cnt_n;
	logic [2:0] bit_q,   bit_n;
	logic [7:0] shift_q, shift_n;
	logic       pres_q,  pres_n;
	logic [7:0] rres_q,  rres_n;
	logic       done_n;
	logic       finished;
	logic [8:0] len;
	logic [8:0] cnt_inc;

	logic       out_valid_q;
	logic       drive_q, busy_q, done_q;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	// length of the current phase
	always_comb begin
		unique case (op_q)
			OP_RESET: len = (phase_q == PH_FIRST)  ? T_RST_LOW :
			                (phase_q == PH_SECOND) ? T_RST_SAMPLE : T_RST_TAIL;
			OP_WRITE: len = (phase_q == PH_FIRST) ?
			                (shift_q[0] ? T_W1_LOW : T_W0_LOW) :
			                (shift_q[0] ? T_W1_REL : T_W0_REL);
			default:  len = (phase_q == PH_FIRST)  ? T_RD_LOW :
			                (phase_q == PH_SECOND) ? T_RD_SAMPLE : T_RD_TAIL;
		endcase
	end

	assign cnt_inc = cnt_q + 9'd1;

	// next state
	always_comb begin
		op_n     = op_q;
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		rres_n   = rres_q;
		finished = 1'b0;
		if (q_item.is_cmd) begin
			// commands are dropped while a sequence runs
			if (op_q == OP_IDLE) begin
				op_n    = q_item.op;
				phase_n = PH_FIRST;
				cnt_n   = 9'd0;
				bit_n   = 3'd0;
				shift_n = (q_item.op == OP_WRITE) ? q_item.data : 8'd0;
			end
		end else if (op_q != OP_IDLE) begin
			cnt_n = cnt_inc;
			if (cnt_inc >= len) begin
				cnt_n = 9'd0;
				unique case (op_q)
					OP_RESET: begin
						if (phase_q == PH_SECOND) begin
							pres_n = ~q_item.level;
						end
						if (phase_q == PH_THIRD) begin
							finished = 1'b1;
						end else begin
							phase_n = phase_q + 2'd1;
						end
					end
					OP_WRITE: begin
						if (phase_q == PH_FIRST) begin
							phase_n = PH_SECOND;
						end else begin
							shift_n  = {1'b0, shift_q[7:1]};
							finished = (bit_q == 3'd7);
							bit_n    = bit_q + 3'd1;
							phase_n  = PH_FIRST;
						end
					end
					default: begin
						// read: sample on the one-microsecond phase
						if (phase_q == PH_SECOND) begin
							shift_n = {q_item.level, shift_q[7:1]};
						end
						if (phase_q == PH_THIRD) begin
							finished = (bit_q == 3'd7);
							bit_n    = bit_q + 3'd1;
							phase_n  = PH_FIRST;
							if (bit_q == 3'd7) begin
								rres_n = shift_q;
							end
						end else begin
							phase_n = phase_q + 2'd1;
						end
					end
				endcase
				if (finished) begin
					op_n    = OP_IDLE;
					phase_n = PH_FIRST;
					bit_n   = 3'd0;
				end
			end
		end
	end

	// result flags
	always_comb begin
		done_n = finished;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_IDLE;
			phase_q     <= PH_FIRST;
			cnt_q       <= 9'd0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			pres_q      <= 1'b0;
			rres_q      <= 8'd0;
			out_valid_q <= 1'b0;
			drive_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				op_q        <= op_n;
				phase_q     <= phase_n;
				cnt_q       <= cnt_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				pres_q      <= pres_n;
				rres_q      <= rres_n;
				drive_q     <= (op_n != OP_IDLE) && (phase_n == PH_FIRST);
				busy_q      <= (op_n != OP_IDLE);
				done_q      <= done_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, rres_q, pres_q, done_q, busy_q, drive_q};

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < T_RST_LOW)
		else $error("microsecond count past longest phase");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_IDLE) |-> (phase_q == PH_FIRST && bit_q == 3'd0 && cnt_q == 9'd0))
		else $error("idle with leftover sequence state");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (!busy_q && !drive_q))
		else $error("done reported while still busy");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_WRITE) |-> (phase_q != PH_THIRD))
		else $error("write slot in a third phase");
`endif

endmodule

`default_nettype wire

[rtl/core/one_wire_bus_master.sv]
// top level of the one-wire bus master
`default_nettype none

// One-wire bus master driven by a stream of items: a one-microsecond tick or one
// of three commands (bus reset with presence detect, write byte, read byte, LSB
// first). Each accepted item produces exactly one result transfer that shows the
// bus drive, busy, done, the presence flag of the last reset and the last byte
// read. Commands that arrive while a sequence runs are ignored; ticks while idle
// change nothing. Timing follows the standard slots: reset 480 us low, sample at
// 70 us, 410 us recovery; write-1 6/64 us, write-0 60/10 us; read 6 us low, sample
// 1 us later, 55 us recovery. The line level is taken from the tick item.
// Throughput is one item per clock while the result side keeps accepting; an input
// transfer passes through the two-entry queue and then the result register. The
// queue lets the input side keep moving while a result waits on the output side.
module one_wire_bus_master (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [7:0] data_byte, [8] line_level, [15:9] zero
	input  wire  [1:0]  s_axis_tuser,  // [1:0] kind
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] drive_low, [1] busy_res, [2] done_res,
	                                   // [3] presence, [11:4] read_byte, [15:12] zero
);
	import owbm_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// front: classify and queue each transfer
	owbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_data  (s_axis_tdata[7:0]),
		.in_level (s_axis_tdata[8]),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back: run the bus sequences and register the result
	owbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

[verif/tb.sv]
// testbench for the one-wire bus master: predicted results checked against the result stream
`default_nettype none

module tb;
	import owbm_pkg::*;

	// result word as it travels on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] read_byte;
		logic       presence;
		logic       done;
		logic       busy;
		logic       drive_low;
	} bus_result_t;

	// how the line level is chosen on the ticks of a sequence
	localparam int LVL_LOW    = 0;
	localparam int LVL_HIGH   = 1;
	localparam int LVL_RANDOM = 2;

	localparam int SEQ_RESET_TICKS = T_RST_LOW + T_RST_SAMPLE + T_RST_TAIL;
	localparam int SEQ_WRITE_TICKS = 8 * (T_W1_LOW + T_W1_REL);
	localparam int SEQ_READ_TICKS  = 8 * (T_RD_LOW + T_RD_SAMPLE + T_RD_TAIL);
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 2000;

	// tracks the bus sequencer and holds the results still to come
	class slot_tracker;
		op_t         op = OP_IDLE;
		logic [1:0]  phase = PH_FIRST;
		logic [8:0]  usec = '0;
		logic [2:0]  bitpos = '0;
		logic [7:0]  shreg = '0;
		logic        presence_q = 1'b0;
		logic [7:0]  rd_byte = '0;
		bus_result_t pending_results[$];
		int          errors = 0;

		function new();
		endfunction

		function void take_item(logic [1:0] kind, logic [7:0] data, logic level);
			logic [8:0]  span;
			logic        finished;
			bus_result_t r;
			finished = 1'b0;
			r = '0;
			if (kind != KIND_TICK) begin
				// commands start only from idle, otherwise dropped
				if (op == OP_IDLE) begin
					op = op_t'(kind);
					phase = PH_FIRST;
					usec = '0;
					bitpos = '0;
					shreg = (kind == KIND_WRITE) ? data : 8'h00;
				end
			end else if (op != OP_IDLE) begin
				case (op)
					OP_RESET: span = (phase == PH_FIRST) ? T_RST_LOW :
						(phase == PH_SECOND) ? T_RST_SAMPLE : T_RST_TAIL;
					OP_WRITE: if (phase == PH_FIRST)
						span = shreg[0] ? T_W1_LOW : T_W0_LOW;
					else
						span = shreg[0] ? T_W1_REL : T_W0_REL;
					default: span = (phase == PH_FIRST) ? T_RD_LOW :
						(phase == PH_SECOND) ? T_RD_SAMPLE : T_RD_TAIL;
				endcase
				usec = usec + 9'd1;
				if (usec >= span) begin
					usec = '0;
					case (op)
						OP_RESET: begin
							// presence: a device holds the line low at the sample point
							if (phase == PH_SECOND)
								presence_q = !level;
							if (phase == PH_THIRD)
								finished = 1'b1;
							else
								phase = phase + 2'd1;
						end
						OP_WRITE: begin
							if (phase == PH_FIRST) begin
								phase = PH_SECOND;
							end else begin
								shreg = shreg >> 1;
								finished = (bitpos == 3'd7);
								bitpos = bitpos + 3'd1;
								phase = PH_FIRST;
							end
						end
						default: begin
							if (phase == PH_SECOND)
								shreg = {level, shreg[7:1]};
							if (phase == PH_THIRD) begin
								finished = (bitpos == 3'd7);
								bitpos = bitpos + 3'd1;
								phase = PH_FIRST;
								if (finished)
									rd_byte = shreg;
							end else begin
								phase = phase + 2'd1;
							end
						end
					endcase
					if (finished) begin
						op = OP_IDLE;
						phase = PH_FIRST;
						bitpos = '0;
						r.done = 1'b1;
					end
				end
			end
			r.drive_low = (op != OP_IDLE) && (phase == PH_FIRST);
			r.busy = (op != OP_IDLE);
			r.presence = presence_q;
			r.read_byte = rd_byte;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [15:0] word);
			bus_result_t want;
			bus_result_t got;
			got = bus_result_t'(word);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, word);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.drive_low !== want.drive_low) begin
				$display("%0t: drive_low expected %0b actual %0b", $time, want.drive_low,
					got.drive_low);
				errors++;
			end
			if (got.busy !== want.busy) begin
				$display("%0t: busy expected %0b actual %0b", $time, want.busy, got.busy);
				errors++;
			end
			if (got.done !== want.done) begin
				$display("%0t: done expected %0b actual %0b", $time, want.done, got.done);
				errors++;
			end
			if (got.presence !== want.presence) begin
				$display("%0t: presence expected %0b actual %0b", $time, want.presence,
					got.presence);
				errors++;
			end
			if (got.read_byte !== want.read_byte) begin
				$display("%0t: read_byte expected %h actual %h", $time, want.read_byte,
					got.read_byte);
				errors++;
			end
			if (got.pad !== want.pad) begin
				$display("%0t: padding expected %h actual %h", $time, want.pad, got.pad);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] data_byte, [8] line_level, [15:9] zero
	logic [1:0]  s_axis_tuser;   // [1:0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [0] drive_low, [1] busy, [2] done, [3] presence, [11:4] read_byte

	slot_tracker tracker;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	int          rx_mode = 0;
	int          rx_left = 0;
	bit          hold_off = 1'b0;

	one_wire_bus_master u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offers one item, called at a rising edge, returns at the edge of its transfer
	task automatic send_item(input logic [1:0] kind, input logic [7:0] data, input logic level);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, level, data};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	// one command and the ticks that carry it to completion
	task automatic run_sequence(input logic [1:0] kind, input logic [7:0] data,
			input int level_pick, input int noise_pct);
		int   span;
		logic lvl;
		case (kind)
			KIND_RESET: span = SEQ_RESET_TICKS;
			KIND_WRITE: span = SEQ_WRITE_TICKS;
			default:    span = SEQ_READ_TICKS;
		endcase
		send_item(kind, data, 1'($urandom_range(0, 1)));
		// a command right behind the start finds the block busy
		if (noise_pct > 0)
			send_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
		for (int i = 0; i < span; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(2'($urandom_range(1, 3)), 8'($urandom),
					1'($urandom_range(0, 1)));
			lvl = (level_pick == LVL_LOW) ? 1'b0 :
				(level_pick == LVL_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
			send_item(KIND_TICK, 8'($urandom), lvl);
		end
	endtask

	// stimulus
	initial begin
		tracker = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_TICK;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle change nothing
		send_item(KIND_TICK, 8'hff, 1'b0);
		send_item(KIND_TICK, 8'h00, 1'b1);
		// receiver holds off once early on so the queue fills
		hold_off = 1'b1;
		// reset answered by a device, busy commands mixed in
		run_sequence(KIND_RESET, 8'h00, LVL_LOW, 2);
		// mixed byte out
		run_sequence(KIND_WRITE, 8'ha5, LVL_RANDOM, 2);
		// read of a noisy line
		run_sequence(KIND_READ, 8'h5a, LVL_RANDOM, 1);
		send_item(KIND_TICK, 8'h3c, 1'b1);
		s_axis_tvalid <= 1'b0;

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// receiver: changing stall patterns, one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(16, 128);
				end
				rx_left--;
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ((rx_left % 5) < 3);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// both sides are stable mid-cycle; a transfer seen here happens at the next rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_result(m_axis_tdata);
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire
